FILE: sv/sliding_window_latency_percentiles_assert.svh
// Assertion macros shared by the latency percentile tracker RTL.
`ifndef SLIDING_WINDOW_LATENCY_PERCENTILES_ASSERT_SVH
`define SLIDING_WINDOW_LATENCY_PERCENTILES_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that holds at every clock edge outside reset.
`define SWLP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("swlp assertion failed");

// Condition that must hold in the cycle after a trigger.
`define SWLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swlp assertion failed");

`else

`define SWLP_ASSERT(label, expr)
`define SWLP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/swlp_pkg.sv
// Types and constants for the sliding window latency percentile tracker.
`default_nettype none

package swlp_pkg;

  localparam int SAMPLE_W = 31;
  localparam int SUM_W    = 63;
  localparam int FILL_W   = 7;

  // floor(m / 100) as (m * RECIP_100) >> RECIP_SHIFT, exact for m < 2^17
  localparam int PROD_M_W    = 17;
  localparam int PROD_W      = 35;
  localparam int P95_NUM     = 95;
  localparam int RECIP_100   = 167773;
  localparam int RECIP_SHIFT = 24;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] latency_sample;
  } swlp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] median_latency;
    logic [SAMPLE_W-1:0] p95_latency;
    logic [SAMPLE_W-1:0] max_latency;
    logic [SUM_W-1:0]    total_latency;
    logic [FILL_W-1:0]   window_fill;
  } swlp_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DEL,
    CELL_INS
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [SAMPLE_W-1:0] key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL,
    S_INS,
    S_RANK,
    S_DONE
  } swlp_state_t;

endpackage

`default_nettype wire

FILE: sv/sliding_window_latency_percentiles.sv
// Sliding window latency tracker: median, 95th percentile, max, sum and fill.
//
// Input channel sample/sample_valid/sample_ready carries a command and a signed
// latency; output channel stats/stats_valid/stats_ready returns one result per
// input transaction, in order.
// A record transaction passes from the accepting edge, where the ring is read
// and the statistics updated, through delete of the oldest value from the
// sorted cell chain once the window is full, insertion of the new value, rank
// select and hand-off to the output register. A clear transaction goes straight
// to hand-off. One item is in work at a time, so a new transaction is accepted
// only after the last one has been handed off; for a record the wait is set by
// the delete and insert passes through the sorted cell chain.
// The output register lets the next transaction be accepted while a result
// still waits; if the receiver stalls, the following result holds in the
// tracker and sample_ready stays low until it moves to the output register.
// Reset empties the window and zeroes sum and maximum; no clearing pass is
// needed since the fill count guards the ring and the cells.
`default_nettype none

`include "sliding_window_latency_percentiles_assert.svh"

module sliding_window_latency_percentiles #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swlp_pkg::swlp_in_t  sample,
  input  wire logic                sample_valid,
  output logic                     sample_ready,
  output swlp_pkg::swlp_out_t      stats,
  output logic                     stats_valid,
  input  wire logic                stats_ready
);
  import swlp_pkg::*;

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  swlp_state_t state, state_next;

  // window bookkeeping
  logic [CW-1:0]       count;
  logic [IW-1:0]       slot;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] max_val;
  logic                was_full;
  logic [SAMPLE_W-1:0] new_val;
  logic [SAMPLE_W-1:0] old_val;
  logic [PROD_M_W-1:0] m95;
  logic [IW-1:0]       rank_med;
  logic [IW-1:0]       rank_p95;
  swlp_out_t           res;

  logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];

  // control
  logic       accept;
  logic       load_out;
  cell_ctrl_t ctrl;

  // datapath helpers
  logic [SAMPLE_W-1:0] clamped;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_next;
  logic [CW-1:0]       count_pre;
  logic [PROD_W-1:0]   prod;
  logic [CW-1:0]       q95;
  logic [CW-1:0]       r95_full;

  // chain signals
  logic [SAMPLE_W-1:0] cell_val  [WINDOW_DEPTH];
  logic                cell_gt   [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] med_part  [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] p95_part  [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] med_or;
  logic [SAMPLE_W-1:0] p95_or;

  assign accept  = sample_valid && sample_ready;
  assign clamped = sample.latency_sample[31] ? '0 : sample.latency_sample[30:0];
  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(clamped);
  assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  // valid cells before the insert pass
  assign count_pre = count - CW'(1);

  // rank of the 95th percentile: floor(n * 95 / 100), capped at n - 1
  assign prod     = PROD_W'(m95) * PROD_W'(RECIP_100);
  assign q95      = prod[RECIP_SHIFT +: CW];
  assign r95_full = (q95 > count_pre) ? count_pre : q95;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and chain control
  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    load_out     = 1'b0;
    ctrl.op      = CELL_HOLD;
    ctrl.key     = old_val;
    unique case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = (sample.command == CMD_CLEAR) ? S_DONE : S_DEL;
        end
      end
      S_DEL: begin
        if (was_full) ctrl.op = CELL_DEL;
        state_next = S_INS;
      end
      S_INS: begin
        ctrl.op    = CELL_INS;
        ctrl.key   = new_val;
        state_next = S_RANK;
      end
      S_RANK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stats_valid || stats_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sample ring: read the oldest entry while the new one overwrites it
  always_ff @(posedge clk) begin
    if (accept && sample.command == CMD_RECORD) begin
      old_val    <= ring[slot];
      ring[slot] <= clamped;
    end
  end

  // running statistics, slot and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      slot    <= '0;
      sum     <= '0;
      max_val <= '0;
    end else if (accept) begin
      if (sample.command == CMD_CLEAR) begin
        count   <= '0;
        slot    <= '0;
        sum     <= '0;
        max_val <= '0;
      end else begin
        sum <= sum_next;
        if (clamped > max_val) max_val <= clamped;
        slot <= (slot == IW'(WINDOW_DEPTH - 1)) ? '0 : slot + IW'(1);
        if (count != CW'(WINDOW_DEPTH)) count <= count + CW'(1);
      end
    end
  end

  // per-transaction payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      new_val  <= clamped;
      was_full <= (count == CW'(WINDOW_DEPTH));
    end
    if (state == S_DEL) begin
      m95 <= PROD_M_W'(count) * PROD_M_W'(P95_NUM);
    end
    if (state == S_INS) begin
      rank_med <= IW'(count_pre >> 1);
      rank_p95 <= IW'(r95_full);
    end
    if (accept && sample.command == CMD_CLEAR) begin
      res <= '0;
    end else if (state == S_RANK) begin
      res.median_latency <= med_or;
      res.p95_latency    <= p95_or;
      res.max_latency    <= max_val;
      res.total_latency  <= sum;
      res.window_fill    <= FILL_W'(count);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (load_out) begin
      stats_valid <= 1'b1;
    end else if (stats_ready) begin
      stats_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) stats <= res;
  end

  // sorted chain of cells
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [SAMPLE_W-1:0] left_value;
    logic                left_greater;
    logic [SAMPLE_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value   = '0;
      assign left_greater = 1'b0;
    end else begin : g_inner
      assign left_value   = cell_val[i-1];
      assign left_greater = cell_gt[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_body
      assign right_value = cell_val[i+1];
    end

    swlp_cell #(
      .DEPTH (WINDOW_DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .count        (count_pre),
      .rank_med     (rank_med),
      .rank_p95     (rank_p95),
      .left_value   (left_value),
      .left_greater (left_greater),
      .right_value  (right_value),
      .value        (cell_val[i]),
      .greater      (cell_gt[i]),
      .med_part     (med_part[i]),
      .p95_part     (p95_part[i])
    );
  end

  // rank taps: exactly one cell matches each rank
  always_comb begin
    med_or = '0;
    p95_or = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      med_or = med_or | med_part[k];
      p95_or = p95_or | p95_part[k];
    end
  end

  // checks
  `SWLP_ASSERT(a_fill_bound, count <= CW'(WINDOW_DEPTH))
  `SWLP_ASSERT(a_slot_tracks_fill, (count == CW'(WINDOW_DEPTH)) || (CW'(slot) == count))
  `SWLP_ASSERT(a_max_within_sum, SUM_W'(max_val) <= sum)
  `SWLP_ASSERT_NEXT(a_rank_then_done, state == S_RANK, state == S_DONE)

endmodule

`default_nettype wire

FILE: sv/swlp_cell.sv
// One cell of the sorted sample chain: holds one window value in ascending order.
`default_nettype none

module swlp_cell #(
  parameter int DEPTH = 64,
  parameter int INDEX = 0,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire swlp_pkg::cell_ctrl_t          ctrl,
  input  wire logic [CW-1:0]                 count,
  input  wire logic [IW-1:0]                 rank_med,
  input  wire logic [IW-1:0]                 rank_p95,
  input  wire logic [swlp_pkg::SAMPLE_W-1:0] left_value,
  input  wire logic                          left_greater,
  input  wire logic [swlp_pkg::SAMPLE_W-1:0] right_value,
  output logic      [swlp_pkg::SAMPLE_W-1:0] value,
  output logic                               greater,
  output logic      [swlp_pkg::SAMPLE_W-1:0] med_part,
  output logic      [swlp_pkg::SAMPLE_W-1:0] p95_part
);
  import swlp_pkg::*;

  logic [SAMPLE_W-1:0] value_next;
  logic                at_or_above;

  // empty cells count as larger than any key
  assign greater     = (CW'(INDEX) >= count) || (value > ctrl.key);
  assign at_or_above = (value >= ctrl.key);

  // delete: cells from the dropped value upward take their right neighbor
  // insert: cells above the key take their left neighbor, the first one the key
  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      CELL_HOLD: value_next = value;
      CELL_DEL: begin
        if (at_or_above) value_next = right_value;
      end
      CELL_INS: begin
        if (greater) value_next = left_greater ? left_value : ctrl.key;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // rank taps, OR-combined across the chain
  assign med_part = (rank_med == IW'(INDEX)) ? value : '0;
  assign p95_part = (rank_p95 == IW'(INDEX)) ? value : '0;

endmodule

`default_nettype wire
